@@ src/vlcp_pkg.sv @@
// ----------------------------------------------------------------------------
// vlcp_pkg
// Shared constants, opcodes and control types of the variable-length code
// packer.
// ----------------------------------------------------------------------------
package vlcp_pkg;

    localparam int MAX_CODE_LEN = 32;
    localparam int SYMBOL_COUNT = 256;

    localparam int SYM_W    = 8;
    localparam int CODE_W   = 32;
    localparam int LEN_W    = 6;
    localparam int BYTE_W   = 8;
    localparam int PAD_W    = 3;
    localparam int ADDR_W   = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
    localparam int ACC_W    = CODE_W + BYTE_W;
    localparam int NBYTES_W = 3;

    // Stored code lengths never exceed this limit.
    localparam int LEN_LIMIT = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;

    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_ENCODE = 2'd1;
    localparam logic [1:0] OP_FINISH = 2'd2;

    typedef struct packed {
        logic align;
        logic finish;
    } pk_ctrl_t;

    typedef struct packed {
        logic pending;
    } pk_status_t;

endpackage

@@ src/vlcp_code_table.sv @@
// ----------------------------------------------------------------------------
// vlcp_code_table
// Code table memory: one entry per symbol holding the masked code bits and
// the clamped code length, with a registered read port.
// ----------------------------------------------------------------------------
module vlcp_code_table
    import vlcp_pkg::*;
(
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [CODE_W-1:0] wr_bits,
    input  logic [LEN_W-1:0]  wr_len,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [CODE_W-1:0] rd_bits,
    output logic [LEN_W-1:0]  rd_len
);

    logic [LEN_W+CODE_W-1:0] mem [SYMBOL_COUNT];
    logic [LEN_W+CODE_W-1:0] rd_data_reg;
    logic [LEN_W-1:0]        len_clamped;
    logic [CODE_W-1:0]       bits_mask;

    // Code bits at or above the length are dropped before they are stored.
    always_comb begin
        len_clamped = (wr_len > LEN_W'(LEN_LIMIT)) ? LEN_W'(LEN_LIMIT) : wr_len;
        if (len_clamped == '0) begin
            bits_mask = '0;
        end else begin
            bits_mask = {CODE_W{1'b1}} >> (LEN_W'(CODE_W) - len_clamped);
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= {len_clamped, wr_bits & bits_mask};
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_bits = rd_data_reg[CODE_W-1:0];
    assign rd_len  = rd_data_reg[LEN_W+CODE_W-1:CODE_W];

endmodule

@@ src/vlcp_pack_unit.sv @@
// ----------------------------------------------------------------------------
// vlcp_pack_unit
// Bit accumulator and byte emitter. The top byte of the accumulator holds the
// partial byte between transactions; completed bytes leave through a single
// output register, one per cycle while m_ready is high.
// ----------------------------------------------------------------------------
module vlcp_pack_unit
    import vlcp_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  pk_ctrl_t          ctrl,
    input  logic [CODE_W-1:0] rd_bits,
    input  logic [LEN_W-1:0]  rd_len,
    output pk_status_t        status,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [BYTE_W-1:0] m_packed_byte,
    output logic [PAD_W-1:0]  m_pad_bits,
    output logic              m_last
);

    logic [ACC_W-1:0]    acc_reg, acc_next;
    logic [2:0]          bc_reg, bc_next;
    logic [NBYTES_W-1:0] nbytes_reg, nbytes_next;
    logic [PAD_W-1:0]    pad_reg, pad_next;
    logic                m_valid_reg, m_valid_next;
    logic [BYTE_W-1:0]   m_byte_reg, m_byte_next;
    logic [PAD_W-1:0]    m_pad_reg, m_pad_next;
    logic                m_last_reg, m_last_next;

    logic [LEN_W-1:0] total;
    logic [LEN_W-1:0] shamt;
    logic [ACC_W-1:0] aligned;
    logic             emit;

    assign total   = LEN_W'({3'b000, bc_reg}) + rd_len;
    assign shamt   = LEN_W'(ACC_W) - total;
    assign aligned = {{(ACC_W-CODE_W){1'b0}}, rd_bits} << shamt;
    assign emit    = (nbytes_reg != '0) && (!m_valid_reg || m_ready);

    always_comb begin
        acc_next     = acc_reg;
        bc_next      = bc_reg;
        nbytes_next  = nbytes_reg;
        pad_next     = pad_reg;
        m_valid_next = m_valid_reg;
        m_byte_next  = m_byte_reg;
        m_pad_next   = m_pad_reg;
        m_last_next  = m_last_reg;

        priority if (ctrl.align) begin
            acc_next    = acc_reg | aligned;
            nbytes_next = NBYTES_W'(total >> 3);
            bc_next     = total[2:0];
            pad_next    = '0;
        end else if (ctrl.finish) begin
            nbytes_next = (bc_reg != '0) ? NBYTES_W'(1) : '0;
            pad_next    = PAD_W'(4'd8 - {1'b0, bc_reg});
            bc_next     = '0;
        end else if (emit) begin
            acc_next    = acc_reg << BYTE_W;
            nbytes_next = nbytes_reg - NBYTES_W'(1);
        end else begin
            acc_next    = acc_reg;
        end

        if (emit) begin
            m_valid_next = 1'b1;
            m_byte_next  = acc_reg[ACC_W-1:ACC_W-BYTE_W];
            m_last_next  = (nbytes_reg == NBYTES_W'(1));
            m_pad_next   = (nbytes_reg == NBYTES_W'(1)) ? pad_reg : '0;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg     <= '0;
            bc_reg      <= '0;
            nbytes_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            acc_reg     <= acc_next;
            bc_reg      <= bc_next;
            nbytes_reg  <= nbytes_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pad_reg    <= pad_next;
        m_byte_reg <= m_byte_next;
        m_pad_reg  <= m_pad_next;
        m_last_reg <= m_last_next;
    end

    assign status.pending = (nbytes_reg != '0);
    assign m_valid        = m_valid_reg;
    assign m_packed_byte  = m_byte_reg;
    assign m_pad_bits     = m_pad_reg;
    assign m_last         = m_last_reg;

    // Once all bytes have left, only the partial byte may hold set bits.
    a_acc_settled: assert property (@(posedge aclk) disable iff (!aresetn)
        (nbytes_reg == '0) |-> (acc_reg[ACC_W-BYTE_W-1:0] == '0))
        else $error("accumulator holds bits below the partial byte");

    a_nbytes_range: assert property (@(posedge aclk) disable iff (!aresetn)
        nbytes_reg <= NBYTES_W'(4))
        else $error("more than four bytes pending");

    a_finish_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.finish |=> (bc_reg == '0))
        else $error("bit count not cleared by a flush");

endmodule

@@ src/variable_length_code_packer.sv @@
// ----------------------------------------------------------------------------
// variable_length_code_packer
// Packs per-symbol prefix codes into a byte stream, most significant bit
// first, using a code table memory and a bit accumulator.
//
//   Channel  Direction  Ports
//   s_       in         s_valid, s_ready, s_opcode, s_symbol, s_code_value,
//                       s_code_length
//   m_       out        m_valid, m_ready, m_packed_byte, m_pad_bits, m_last
//
// A load or an unused opcode is accepted in idle. An encode reads the table,
// aligns the code into the accumulator, emits each completed byte (up to
// four) and returns to idle. A flush emits the partial byte, if there is
// one, and returns to idle.
// The single output register passes one byte per cycle while m_ready is high.
// Reset is synchronous and clears the partial byte and bit count; the code
// table is not cleared and must be loaded before use.
// A stalled m_ready holds the emitter; s_ready stays low until it finishes.
// ----------------------------------------------------------------------------
module variable_length_code_packer
    import vlcp_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_opcode,
    input  logic [SYM_W-1:0]  s_symbol,
    input  logic [CODE_W-1:0] s_code_value,
    input  logic [LEN_W-1:0]  s_code_length,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [BYTE_W-1:0] m_packed_byte,
    output logic [PAD_W-1:0]  m_pad_bits,
    output logic              m_last
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ALIGN = 2'd1;
    localparam logic [1:0] ST_EMIT  = 2'd2;

    logic [1:0] state_reg, state_next;

    logic              accept;
    logic              sym_ok;
    logic              wr_en;
    logic              rd_en;
    logic [CODE_W-1:0] rd_bits;
    logic [LEN_W-1:0]  rd_len;
    pk_ctrl_t          ctrl;
    pk_status_t        status;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign sym_ok  = ({1'b0, s_symbol} < 9'(SYMBOL_COUNT));
    assign wr_en   = accept && (s_opcode == OP_LOAD) && sym_ok;
    assign rd_en   = accept && (s_opcode == OP_ENCODE) && sym_ok;

    assign ctrl.align  = (state_reg == ST_ALIGN);
    assign ctrl.finish = accept && (s_opcode == OP_FINISH);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (rd_en) begin
                    state_next = ST_ALIGN;
                end else if (ctrl.finish) begin
                    state_next = ST_EMIT;
                end
            end
            ST_ALIGN: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (!status.pending) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    vlcp_code_table u_table (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (s_symbol[ADDR_W-1:0]),
        .wr_bits (s_code_value),
        .wr_len  (s_code_length),
        .rd_en   (rd_en),
        .rd_addr (s_symbol[ADDR_W-1:0]),
        .rd_bits (rd_bits),
        .rd_len  (rd_len)
    );

    vlcp_pack_unit u_pack (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .ctrl          (ctrl),
        .rd_bits       (rd_bits),
        .rd_len        (rd_len),
        .status        (status),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_packed_byte (m_packed_byte),
        .m_pad_bits    (m_pad_bits),
        .m_last        (m_last)
    );

    // The align step must use data read for an encode in the previous cycle.
    a_align_follows_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ALIGN) |-> $past(rd_en))
        else $error("align without a preceding table read");

    a_finish_to_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.finish |=> (state_reg == ST_EMIT))
        else $error("flush did not start emission");

endmodule

@@ tb/sv/tb_variable_length_code_packer.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_variable_length_code_packer
// Self-checking testbench for the variable-length code packer. A scoreboard
// keeps its own code table and bit accumulator, predicts every byte that a
// load, encode or finish transaction produces, and compares each output
// transaction with the oldest prediction. Directed transactions cover the
// code length extremes, empty codes, over-long codes and flushes; random
// transactions follow, with both sides idling at random and a long receiver
// hold-off that backs the block up.
// ----------------------------------------------------------------------------

class byte_stream_scoreboard;

    typedef struct packed {
        logic [vlcp_pkg::BYTE_W-1:0] packed_byte;
        logic [vlcp_pkg::PAD_W-1:0]  pad_bits;
        logic                        last;
    } out_byte_t;

    logic [vlcp_pkg::CODE_W-1:0] code_bits [vlcp_pkg::SYMBOL_COUNT];
    logic [vlcp_pkg::LEN_W-1:0]  code_lens [vlcp_pkg::SYMBOL_COUNT];
    logic [vlcp_pkg::BYTE_W-1:0] partial;
    int unsigned                 bit_count;
    out_byte_t                   pending_bytes[$];
    int                          error_count;

    function new();
        foreach (code_bits[i]) begin
            code_bits[i] = '0;
            code_lens[i] = '0;
        end
        partial     = '0;
        bit_count   = 0;
        error_count = 0;
    endfunction

    task report(input string msg);
        error_count++;
        if (error_count <= 50) begin
            $display("ERROR at %0t ns: %s", $time, msg);
        end
    endtask

    function void note_item(input logic [1:0] op, input logic [7:0] sym,
                            input logic [31:0] val, input logic [5:0] len);
        int        n;
        out_byte_t b;
        n = 0;
        case (op)
            vlcp_pkg::OP_LOAD: begin
                if (sym < vlcp_pkg::SYMBOL_COUNT) begin
                    if (len > vlcp_pkg::LEN_LIMIT) begin
                        len = 6'(vlcp_pkg::LEN_LIMIT);
                    end
                    code_bits[sym] = val;
                    code_lens[sym] = len;
                end
            end
            vlcp_pkg::OP_ENCODE: begin
                if (sym < vlcp_pkg::SYMBOL_COUNT) begin
                    for (int i = code_lens[sym]; i > 0; i--) begin
                        if (code_bits[sym][i-1]) begin
                            partial[7-bit_count] = 1'b1;
                        end
                        bit_count++;
                        if (bit_count == 8) begin
                            pending_bytes.push_back('{partial, '0, 1'b0});
                            n++;
                            partial   = '0;
                            bit_count = 0;
                        end
                    end
                    if (n > 0) begin
                        b      = pending_bytes.pop_back();
                        b.last = 1'b1;
                        pending_bytes.push_back(b);
                    end
                end
            end
            vlcp_pkg::OP_FINISH: begin
                if (bit_count != 0) begin
                    pending_bytes.push_back('{partial, 3'(8 - bit_count), 1'b1});
                end
                partial   = '0;
                bit_count = 0;
            end
            default: begin
            end
        endcase
    endfunction

    task check_byte(input logic [7:0] byte_val, input logic [2:0] pad,
                    input logic is_last);
        out_byte_t exp;
        if (pending_bytes.size() == 0) begin
            report($sformatf("unexpected output byte %02h pad %0d last %0b",
                             byte_val, pad, is_last));
        end else begin
            exp = pending_bytes.pop_front();
            if (byte_val !== exp.packed_byte || pad !== exp.pad_bits ||
                is_last !== exp.last) begin
                report($sformatf({"got byte %02h pad %0d last %0b, ",
                                  "expected %02h pad %0d last %0b"},
                                 byte_val, pad, is_last,
                                 exp.packed_byte, exp.pad_bits, exp.last));
            end
        end
    endtask

endclass

module tb_variable_length_code_packer;
    import vlcp_pkg::*;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         SETTLE_CYCLES = 20;
    localparam int         HOLD_OFF_CYCLES = 300;

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    logic [1:0]        s_opcode;
    logic [SYM_W-1:0]  s_symbol;
    logic [CODE_W-1:0] s_code_value;
    logic [LEN_W-1:0]  s_code_length;
    logic              m_valid;
    logic              m_ready;
    logic [BYTE_W-1:0] m_packed_byte;
    logic [PAD_W-1:0]  m_pad_bits;
    logic              m_last;

    int                    send_idle_pct;
    int                    recv_idle_pct;
    int                    hold_count;
    bit                    is_loaded [SYMBOL_COUNT];
    logic [SYM_W-1:0]      loaded_syms[$];
    byte_stream_scoreboard stream_sb;

    variable_length_code_packer DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_opcode      (s_opcode),
        .s_symbol      (s_symbol),
        .s_code_value  (s_code_value),
        .s_code_length (s_code_length),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_packed_byte (m_packed_byte),
        .m_pad_bits    (m_pad_bits),
        .m_last        (m_last)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #3_000_000;
        $display("Some tests failed");
        $finish;
    end

    always @(negedge aclk) begin
        if (hold_count > 0) begin
            m_ready = 1'b0;
            hold_count--;
        end else begin
            m_ready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            stream_sb.check_byte(m_packed_byte, m_pad_bits, m_last);
        end
    end

    task automatic send_item(input logic [1:0] op, input logic [7:0] sym,
                             input logic [31:0] val, input logic [5:0] len);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid       = 1'b1;
        s_opcode      = op;
        s_symbol      = sym;
        s_code_value  = val;
        s_code_length = len;
        do @(posedge aclk); while (!s_ready);
        stream_sb.note_item(op, sym, val, len);
        @(negedge aclk);
    endtask

    task automatic load_entry(input logic [7:0] sym, input logic [31:0] val,
                              input logic [5:0] len);
        send_item(OP_LOAD, sym, val, len);
        if (!is_loaded[sym]) begin
            is_loaded[sym] = 1'b1;
            loaded_syms.push_back(sym);
        end
    endtask

    task automatic send_random_item();
        int unsigned pick;
        int unsigned len_pick;
        logic [5:0]  len;
        pick = $urandom_range(99);
        if (pick < 15 || loaded_syms.size() == 0) begin
            len_pick = $urandom_range(99);
            if (len_pick < 3) begin
                len = 6'd0;
            end else if (len_pick < 60) begin
                len = 6'($urandom_range(8, 1));
            end else if (len_pick < 85) begin
                len = 6'($urandom_range(20, 9));
            end else if (len_pick < 95) begin
                len = 6'($urandom_range(32, 21));
            end else begin
                len = 6'($urandom_range(63, 33));
            end
            load_entry(8'($urandom), $urandom, len);
        end else if (pick < 83) begin
            send_item(OP_ENCODE, loaded_syms[$urandom_range(loaded_syms.size() - 1)],
                      $urandom, 6'($urandom));
        end else if (pick < 95) begin
            send_item(OP_FINISH, 8'($urandom), $urandom, 6'($urandom));
        end else begin
            send_item(OP_UNUSED, 8'($urandom), $urandom, 6'($urandom));
        end
    endtask

    task automatic wait_drained();
        s_valid = 1'b0;
        while (stream_sb.pending_bytes.size() != 0) begin
            @(negedge aclk);
        end
    endtask

    initial begin
        stream_sb     = new();
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_opcode      = OP_LOAD;
        s_symbol      = '0;
        s_code_value  = '0;
        s_code_length = '0;
        m_ready       = 1'b0;
        hold_count    = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        foreach (is_loaded[i]) begin
            is_loaded[i] = 1'b0;
        end
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        send_idle_pct = 26;
        recv_idle_pct = 73;

        load_entry(8'd0,   32'hFFFF_FFFF, 6'd32);
        load_entry(8'd255, 32'h0000_0000, 6'd32);
        load_entry(8'd1,   32'h0000_0001, 6'd1);
        load_entry(8'd2,   32'hFFFF_FFFF, 6'd63);
        load_entry(8'd3,   32'hAAAA_AAAA, 6'd0);
        load_entry(8'd4,   32'hFFFF_FFF5, 6'd3);
        load_entry(8'd5,   32'h8000_0001, 6'd33);
        send_item(OP_ENCODE, 8'd1, '0, '0);
        send_item(OP_ENCODE, 8'd0, '0, '0);
        send_item(OP_FINISH, '0, '0, '0);
        send_item(OP_FINISH, 8'hFF, 32'hFFFF_FFFF, 6'h3F);
        send_item(OP_ENCODE, 8'd3, '0, '0);
        send_item(OP_ENCODE, 8'd255, 32'hFFFF_FFFF, 6'h3F);
        send_item(OP_ENCODE, 8'd4, '0, '0);
        send_item(OP_ENCODE, 8'd2, '0, '0);
        send_item(OP_UNUSED, 8'hFF, 32'hFFFF_FFFF, 6'h3F);
        send_item(OP_ENCODE, 8'd5, '0, '0);
        send_item(OP_ENCODE, 8'd4, '0, '0);
        send_item(OP_FINISH, '0, '0, '0);
        send_item(OP_ENCODE, 8'd1, '0, '0);
        send_item(OP_FINISH, '0, '0, '0);

        repeat (100) send_random_item();
        wait_drained();

        send_idle_pct = 73;
        recv_idle_pct = 26;
        repeat (100) send_random_item();
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (40) send_random_item();
        hold_count = HOLD_OFF_CYCLES;
        repeat (70) send_random_item();

        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge aclk);

        if (stream_sb.error_count == 0 && stream_sb.pending_bytes.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
src/vlcp_pkg.sv
src/vlcp_code_table.sv
src/vlcp_pack_unit.sv
src/variable_length_code_packer.sv
tb/sv/tb_variable_length_code_packer.sv
